// ===== sv/mkcd_pkg.sv =====
// Shared types and constants of the multi-key click detector.
package mkcd_pkg;

   // Opcodes of a request transfer
   localparam logic [2:0] OP_TICK       = 3'd0;
   localparam logic [2:0] OP_FETCH      = 3'd1;
   localparam logic [2:0] OP_BLOCK      = 3'd2;
   localparam logic [2:0] OP_SET_BLOCK  = 3'd3;
   localparam logic [2:0] OP_CLEAR_HOLD = 3'd4;
   localparam logic [2:0] OP_READ       = 3'd5;

   // Event codes
   localparam logic [1:0] EV_NONE   = 2'd0;
   localparam logic [1:0] EV_CLICK  = 2'd1;
   localparam logic [1:0] EV_DOUBLE = 2'd2;

   localparam logic [15:0] WINDOW_RESET = 16'd200;
   localparam logic [31:0] TIME_MAX     = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  key_levels;
      logic [31:0] elapsed_ticks;
      logic [2:0]  key_index;
      logic [31:0] block_duration;
   } req_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [2:0]  event_key;
      logic [31:0] hold_time;
      logic [31:0] last_hold_time;
      logic [7:0]  pressed_mask;
   } rsp_type;

   // Per-key state record
   typedef struct packed {
      logic [31:0] hold_time;
      logic [31:0] rel_time;
      logic [31:0] blk_time;
      logic [31:0] saved_hold;
      logic        once;
      logic        level;
      logic [1:0]  pending;
   } key_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_SCAN,
      ST_EXEC,
      ST_RESULT
   } state_type;

endpackage

// ===== sv/mkcd_key_unit.sv =====
// Shared per-key update unit: one tick applied to one key record.
module mkcd_key_unit (
   input  mkcd_pkg::key_type cur,
   input  logic              down,
   input  logic [31:0]       dt,
   input  logic [15:0]       window,
   output mkcd_pkg::key_type nxt
);

   logic [31:0] blk_left;
   logic [31:0] acc;
   logic [32:0] sum;
   logic [31:0] acc_sat;
   logic [1:0]  ev;

   assign blk_left = (cur.blk_time > dt) ? (cur.blk_time - dt) : '0;
   assign acc      = down ? cur.hold_time : cur.rel_time;
   assign sum      = {1'b0, acc} + {1'b0, dt};
   assign acc_sat  = sum[32] ? mkcd_pkg::TIME_MAX : sum[31:0];

   always_comb begin
      nxt          = cur;
      nxt.blk_time = blk_left;
      ev           = mkcd_pkg::EV_NONE;
      if (down != cur.level) begin
         if (down) begin
            if ((cur.rel_time != '0) && (cur.rel_time < {16'd0, window})) begin
               ev = mkcd_pkg::EV_DOUBLE;
            end
            nxt.rel_time  = '0;
            nxt.hold_time = 32'd1;
         end else begin
            ev             = mkcd_pkg::EV_CLICK;
            nxt.saved_hold = cur.hold_time;
            nxt.hold_time  = '0;
            nxt.rel_time   = 32'd1;
         end
         // suppress: one-shot flag first, then running block timer
         if (cur.once) begin
            ev       = mkcd_pkg::EV_NONE;
            nxt.once = 1'b0;
         end else if (blk_left != '0) begin
            ev = mkcd_pkg::EV_NONE;
         end
         nxt.pending = ev;
         nxt.level   = down;
      end else if (down) begin
         nxt.hold_time = acc_sat;
      end else begin
         nxt.rel_time = acc_sat;
      end
   end

endmodule

// ===== sv/multi_key_click_detector_unit.sv =====
// Top level of the multi-key click detector: sequencer, key store and result register.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------------
//   request | req_valid, req_ready, req_payload | one command per transfer
//   result  | rsp_valid, rsp_ready, rsp_payload | exactly one result per command
//   config  | csr_we, csr_wdata              | double-click window, no wait state
//
// Tick with nonzero elapsed time: one key per cycle through the shared update unit,
// every key in turn, then the result state loads the result register.
// Fetch: one key per cycle from the scan pointer, up to the first pending event.
// Reset is synchronous, active high, and clears all key state at once, no sweep.
// req_ready is high only while the sequencer is idle; a waiting result stalls the
// next command in its last state, not its transfer.
module multi_key_click_detector_unit #(
   parameter int NUM_KEYS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mkcd_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mkcd_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);

   localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam logic [KW-1:0] LAST_KEY = KW'(NUM_KEYS - 1);

   mkcd_pkg::state_type state_ff, state_in;
   mkcd_pkg::key_type   key_ff [NUM_KEYS];
   logic [KW-1:0]       idx_ff, idx_in;
   logic [KW-1:0]       cnt_ff, cnt_in;
   logic [KW-1:0]       ptr_ff, ptr_in;
   mkcd_pkg::req_type   req_ff, req_in;
   mkcd_pkg::rsp_type   res_ff, res_in;
   mkcd_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [15:0]         window_ff;

   mkcd_pkg::key_type   cur;
   mkcd_pkg::key_type   tick_nxt;
   mkcd_pkg::key_type   key_wr;
   logic                key_we;
   logic [NUM_KEYS-1:0] down_vec;
   logic [7:0]          mask;
   logic [KW-1:0]       next_idx;
   logic [KW-1:0]       kidx;
   logic [31:0]         kwide;
   logic [31:0]         idx_wide;
   logic                key_ok;

   // Pressed level per key; keys past the level field read as released
   for (genvar k = 0; k < NUM_KEYS; k++) begin : g_down
      if (k < 8) begin : g_pin
         assign down_vec[k] = ~req_ff.key_levels[k];
      end else begin : g_none
         assign down_vec[k] = 1'b0;
      end
   end

   // Pressed mask follows the stored level of the first eight keys
   for (genvar k = 0; k < 8; k++) begin : g_mask
      if (k < NUM_KEYS) begin : g_key
         assign mask[k] = key_ff[k].level;
      end else begin : g_pad
         assign mask[k] = 1'b0;
      end
   end

   assign cur      = key_ff[idx_ff];
   assign next_idx = (idx_ff == LAST_KEY) ? '0 : idx_ff + 1'b1;
   assign kwide    = 32'(req_payload.key_index);
   assign kidx     = kwide[KW-1:0];
   assign idx_wide = 32'(idx_ff);
   assign key_ok   = 32'(req_ff.key_index) < 32'(NUM_KEYS);

   mkcd_key_unit u_key_unit (
      .cur    (cur),
      .down   (down_vec[idx_ff]),
      .dt     (req_ff.elapsed_ticks),
      .window (window_ff),
      .nxt    (tick_nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mkcd_pkg::ST_IDLE;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         window_ff    <= mkcd_pkg::WINDOW_RESET;
         for (int k = 0; k < NUM_KEYS; k++) begin
            key_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            window_ff <= csr_wdata;
         end
         if (key_we) begin
            key_ff[idx_ff] <= key_wr;
         end
      end
   end

   // Payload registers, no reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      ptr_in       = ptr_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      key_we       = 1'b0;
      key_wr       = cur;
      req_ready    = 1'b0;
      unique case (state_ff)
         mkcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req_payload;
               res_in = '0;
               cnt_in = '0;
               priority if (req_payload.opcode == mkcd_pkg::OP_TICK &&
                            req_payload.elapsed_ticks != '0) begin
                  idx_in   = '0;
                  state_in = mkcd_pkg::ST_TICK;
               end else if (req_payload.opcode == mkcd_pkg::OP_FETCH) begin
                  idx_in   = ptr_ff;
                  state_in = mkcd_pkg::ST_SCAN;
               end else begin
                  idx_in   = kidx;
                  state_in = mkcd_pkg::ST_EXEC;
               end
            end
         end
         mkcd_pkg::ST_TICK: begin
            // update one key per cycle, write back in place
            key_we = 1'b1;
            key_wr = tick_nxt;
            if (idx_ff == LAST_KEY) begin
               state_in = mkcd_pkg::ST_RESULT;
            end else begin
               idx_in = next_idx;
            end
         end
         mkcd_pkg::ST_SCAN: begin
            if (cur.pending != mkcd_pkg::EV_NONE) begin
               // take the event, park the pointer on this key
               res_in.event_kind = cur.pending;
               res_in.event_key  = idx_wide[2:0];
               key_we            = 1'b1;
               key_wr.pending    = mkcd_pkg::EV_NONE;
               ptr_in            = idx_ff;
               state_in          = mkcd_pkg::ST_RESULT;
            end else if (cnt_ff == LAST_KEY) begin
               state_in = mkcd_pkg::ST_RESULT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               idx_in = next_idx;
            end
         end
         mkcd_pkg::ST_EXEC: begin
            if (key_ok) begin
               unique case (req_ff.opcode)
                  mkcd_pkg::OP_BLOCK: begin
                     key_we      = 1'b1;
                     key_wr.once = 1'b1;
                  end
                  mkcd_pkg::OP_SET_BLOCK: begin
                     key_we          = 1'b1;
                     key_wr.blk_time = req_ff.block_duration;
                  end
                  mkcd_pkg::OP_CLEAR_HOLD: begin
                     key_we           = 1'b1;
                     key_wr.hold_time = '0;
                  end
                  mkcd_pkg::OP_READ: begin
                     res_in.hold_time      = cur.hold_time;
                     res_in.last_hold_time = cur.saved_hold;
                  end
                  default: begin
                  end
               endcase
            end
            state_in = mkcd_pkg::ST_RESULT;
         end
         mkcd_pkg::ST_RESULT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in              = res_ff;
               rsp_in.pressed_mask = mask;
               rsp_valid_in        = 1'b1;
               state_in            = mkcd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mkcd_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/mkcd_checker.sv =====
// Port-level checker for the multi-key click detector, bound to the top level.
module mkcd_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mkcd_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before transfer");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_payload))
      else $error("stalled result changed");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_no_event_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.event_kind == mkcd_pkg::EV_NONE |->
         rsp_payload.event_key == 3'd0)
      else $error("key reported without event");

   a_read_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.hold_time != '0 || rsp_payload.last_hold_time != '0) |->
         rsp_payload.event_kind == mkcd_pkg::EV_NONE)
      else $error("times and event in one result");

endmodule

bind multi_key_click_detector_unit mkcd_checker u_mkcd_checker (.*);
